// ----- sv/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Shared sizes, codes and interface types of the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);

  // fixed field widths
  localparam int OP_BITS    = 3;
  localparam int CNT_BITS   = 9;
  localparam int STAT_BITS  = 2;
  localparam int RDV_BITS   = 32;
  localparam int ITEM_BITS  = 32;

  localparam int IN_BITS    = 48;  // 44 used
  localparam int OUT_BITS   = 64;  // 61 used

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SORTED = 3'd1;
  localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_GET    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SET    = 3'd5;
  localparam logic [OP_BITS-1:0] OP_FIND   = 3'd6;

  localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_COMPACT,
    S_ACCESS,
    S_GETCAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [CNT_BITS-1:0]  index;
    logic [RDV_BITS-1:0]  read_value;
    logic [CNT_BITS-1:0]  removed_count;
    logic [CNT_BITS-1:0]  occupancy;
  } res_t;

endpackage

// ----- sv/positional_sequence_store_core.sv -----
// ----------------------------------------------------------------------------
// positional_sequence_store_core
// Ordered list of up to 256 values held in a single-port-pair RAM, with
// positional and value-based insert, erase, get, set and find.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation (op, pos, item_value in in_tdata).
//   out_* : exactly one result beat per operation, in order.
//   One operation is worked at a time; in_tready is high only while the
//   sequencer is idle. A rejected or unused op goes straight to the result;
//   get and set access one entry; insert and erase move the entries from
//   pos to the end; sorted insert scans for its place, then shifts;
//   remove-all and find scan the held entries. The RAM read/compare/
//   write-back pass moves one entry per cycle.
//   The result register parts the two sides: the next beat is taken while a
//   result waits; that next result then waits in the sequencer until
//   out_tready frees the register.
//   Reset (rst_n low, synchronous) empties the store (count 0); RAM
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module positional_sequence_store_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] op, [11:3] pos, [43:12] item_value, [47:44] zero
  input  logic [pss_pkg::IN_BITS-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] status, [10:2] index, [42:11] read_value, [51:43] removed_count,
  // [60:52] occupancy, [63:61] zero
  output logic [pss_pkg::OUT_BITS-1:0]  out_tdata
);

  pss_pkg::mem_req_t              mem_req;
  logic [pss_pkg::VALUE_BITS-1:0] mem_rdata;
  pss_pkg::res_t                  res;
  logic                           res_valid;
  logic                           res_ready;

  logic                           out_valid_r, out_valid_nxt;
  pss_pkg::res_t                  out_res_r, out_res_nxt;

  pss_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[2:0]),
    .in_pos    (in_tdata[11:3]),
    .in_val    (in_tdata[43:12]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.occupancy, out_res_r.removed_count,
                       out_res_r.read_value, out_res_r.index, out_res_r.status};

endmodule

// ----- sv/pss_ram.sv -----
// ----------------------------------------------------------------------------
// pss_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pss_ram (
  input  logic                           clk,
  input  pss_pkg::mem_req_t              req,
  output logic [pss_pkg::VALUE_BITS-1:0] rdata
);

  logic [pss_pkg::VALUE_BITS-1:0] ram_r [pss_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      ram_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= ram_r[req.raddr];
    end
  end

endmodule

// ----- sv/pss_ctrl.sv -----
// ----------------------------------------------------------------------------
// pss_ctrl
// Operation sequencer: decodes one item, walks the entry store with
// pipelined read/modify/write passes and builds the result.
// ----------------------------------------------------------------------------
module pss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pss_pkg::OP_BITS-1:0]    in_op,
  input  logic [pss_pkg::CNT_BITS-1:0]   in_pos,
  input  logic [pss_pkg::ITEM_BITS-1:0]  in_val,
  output pss_pkg::mem_req_t              mem_req,
  input  logic [pss_pkg::VALUE_BITS-1:0] mem_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pss_pkg::res_t                  res
);

  localparam logic [pss_pkg::CNT_BITS-1:0] CAP = pss_pkg::CNT_BITS'(pss_pkg::CAPACITY);
  localparam int AB = pss_pkg::ADDR_BITS;

  pss_pkg::state_t state_r, state_nxt;

  logic [pss_pkg::OP_BITS-1:0]    op_r, op_nxt;
  logic [pss_pkg::CNT_BITS-1:0]   pos_r, pos_nxt;
  logic [pss_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic [pss_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [pss_pkg::CNT_BITS-1:0]   ra_r, ra_nxt;
  logic [pss_pkg::CNT_BITS-1:0]   ei_r, ei_nxt;
  logic [pss_pkg::CNT_BITS-1:0]   w_r, w_nxt;
  logic                           iss_r, iss_nxt;
  logic                           ev_r, ev_nxt;
  pss_pkg::res_t                  res_r, res_nxt;

  logic                           issue;
  logic                           hit;
  logic                           drop;
  logic [pss_pkg::CNT_BITS-1:0]   ei_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pss_pkg::S_IDLE;
      cnt_r   <= '0;
      iss_r   <= 1'b0;
      ev_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      iss_r   <= iss_nxt;
      ev_r    <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    ra_r  <= ra_nxt;
    ei_r  <= ei_nxt;
    w_r   <= w_nxt;
    res_r <= res_nxt;
  end

  assign issue  = (ra_r < cnt_r);
  assign ei_inc = ei_r + 1'b1;
  assign hit    = (op_r == pss_pkg::OP_FIND) ? (mem_rdata == val_r) : (val_r <= mem_rdata);
  assign drop   = (op_r == pss_pkg::OP_ERASE) ? (ei_r == pos_r) : (mem_rdata == val_r);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    ra_nxt    = ra_r;
    ei_nxt    = ei_r;
    w_nxt     = w_r;
    iss_nxt   = iss_r;
    ev_nxt    = ev_r;
    res_nxt   = res_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      pss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_op;
          pos_nxt = in_pos;
          val_nxt = in_val[pss_pkg::VALUE_BITS-1:0];
          res_nxt = '0;
          ra_nxt  = '0;
          w_nxt   = '0;
          ev_nxt  = 1'b0;
          unique case (in_op)
            pss_pkg::OP_INSERT: begin
              if (in_pos > cnt_r) begin
                res_nxt.status = pss_pkg::STAT_RANGE;
                state_nxt      = pss_pkg::S_DONE;
              end else if (cnt_r >= CAP) begin
                res_nxt.status = pss_pkg::STAT_FULL;
                state_nxt      = pss_pkg::S_DONE;
              end else begin
                ra_nxt    = cnt_r - 1'b1;
                iss_nxt   = (cnt_r != in_pos);
                state_nxt = pss_pkg::S_SHIFT;
              end
            end
            pss_pkg::OP_SORTED: begin
              if (cnt_r >= CAP) begin
                res_nxt.status = pss_pkg::STAT_FULL;
                state_nxt      = pss_pkg::S_DONE;
              end else begin
                state_nxt = pss_pkg::S_SCAN;
              end
            end
            pss_pkg::OP_ERASE: begin
              if (in_pos >= cnt_r) begin
                res_nxt.status = pss_pkg::STAT_RANGE;
                state_nxt      = pss_pkg::S_DONE;
              end else begin
                ra_nxt    = in_pos;
                w_nxt     = in_pos;
                state_nxt = pss_pkg::S_COMPACT;
              end
            end
            pss_pkg::OP_REMOVE: begin
              state_nxt = pss_pkg::S_COMPACT;
            end
            pss_pkg::OP_GET, pss_pkg::OP_SET: begin
              if (in_pos >= cnt_r) begin
                res_nxt.status = pss_pkg::STAT_RANGE;
                state_nxt      = pss_pkg::S_DONE;
              end else begin
                state_nxt = pss_pkg::S_ACCESS;
              end
            end
            pss_pkg::OP_FIND: begin
              state_nxt = pss_pkg::S_SCAN;
            end
            default: begin
              state_nxt = pss_pkg::S_DONE;
            end
          endcase
        end
      end

      // forward scan, one read a cycle, compare in the cycle after the read
      pss_pkg::S_SCAN: begin
        mem_req.re    = issue;
        mem_req.raddr = ra_r[AB-1:0];
        ev_nxt        = issue;
        ei_nxt        = ra_r;
        ra_nxt        = ra_r + 1'b1;
        if (ev_r && hit) begin
          if (op_r == pss_pkg::OP_FIND) begin
            res_nxt.index = ei_r;
            state_nxt     = pss_pkg::S_DONE;
          end else begin
            pos_nxt   = ei_r;
            ra_nxt    = cnt_r - 1'b1;
            iss_nxt   = (cnt_r != ei_r);
            ev_nxt    = 1'b0;
            state_nxt = pss_pkg::S_SHIFT;
          end
        end else if (!ev_r && !issue) begin
          if (op_r == pss_pkg::OP_FIND) begin
            res_nxt.status = pss_pkg::STAT_NOTFOUND;
            state_nxt      = pss_pkg::S_DONE;
          end else begin
            pos_nxt   = cnt_r;
            iss_nxt   = 1'b0;
            ev_nxt    = 1'b0;
            state_nxt = pss_pkg::S_SHIFT;
          end
        end
      end

      // open a gap at pos_r: walk down from the top, each entry moves up one
      pss_pkg::S_SHIFT: begin
        mem_req.re    = iss_r;
        mem_req.raddr = ra_r[AB-1:0];
        if (iss_r) begin
          iss_nxt = (ra_r != pos_r);
          ra_nxt  = ra_r - 1'b1;
        end
        ev_nxt = iss_r;
        ei_nxt = ra_r;
        if (ev_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ei_inc[AB-1:0];
          mem_req.wdata = mem_rdata;
        end else if (!iss_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r[AB-1:0];
          mem_req.wdata = val_r;
          cnt_nxt       = cnt_r + 1'b1;
          res_nxt.index = pos_r;
          state_nxt     = pss_pkg::S_DONE;
        end
      end

      // keep-or-drop pass; write pointer trails the read pointer
      pss_pkg::S_COMPACT: begin
        mem_req.re    = issue;
        mem_req.raddr = ra_r[AB-1:0];
        ev_nxt        = issue;
        ei_nxt        = ra_r;
        ra_nxt        = ra_r + 1'b1;
        if (ev_r && !drop) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = w_r[AB-1:0];
          mem_req.wdata = mem_rdata;
          w_nxt         = w_r + 1'b1;
        end else if (!ev_r && !issue) begin
          cnt_nxt = w_r;
          if (op_r == pss_pkg::OP_ERASE) begin
            res_nxt.index = pos_r;
          end else begin
            res_nxt.removed_count = cnt_r - w_r;
          end
          state_nxt = pss_pkg::S_DONE;
        end
      end

      pss_pkg::S_ACCESS: begin
        if (op_r == pss_pkg::OP_GET) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pos_r[AB-1:0];
          state_nxt     = pss_pkg::S_GETCAP;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r[AB-1:0];
          mem_req.wdata = val_r;
          res_nxt.index = pos_r;
          state_nxt     = pss_pkg::S_DONE;
        end
      end

      pss_pkg::S_GETCAP: begin
        res_nxt.read_value = pss_pkg::RDV_BITS'(mem_rdata);
        res_nxt.index      = pos_r;
        state_nxt          = pss_pkg::S_DONE;
      end

      pss_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = pss_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pss_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res           = res_r;
    res.occupancy = cnt_r;
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP)
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.re && mem_req.we) |-> (mem_req.raddr != mem_req.waddr))
    else $error("read and write hit the same entry");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (pss_pkg::CNT_BITS'(mem_req.waddr) <= cnt_r))
    else $error("write beyond the held entries");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == pss_pkg::STAT_FULL) |-> (cnt_r == CAP))
    else $error("full status with room left");

endmodule
